// ----- rtl/drc_pkg.sv -----
package drc_pkg;

   localparam int MAX_NODES = 256;
   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int CNT_W     = IDX_W + 1;
   localparam int ID_W      = 31;
   localparam int PAIR_W    = 15;

   typedef enum logic [1:0] {
      KIND_DECLARE = 2'd0,
      KIND_EDGE    = 2'd1,
      KIND_COMPUTE = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_UNKNOWN   = 3'd2,
      ST_FULL      = 3'd3,
      ST_TOTALS    = 3'd4,
      ST_CLEARED   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_CMP,
      S_EDGE_RD,
      S_EDGE_WR,
      S_CLEAR,
      S_LOOP_RD,
      S_LOOP_WR,
      S_PAIR_ROW,
      S_PAIR_CACHE,
      S_PAIR_RD,
      S_PAIR_CMP,
      S_RESPOND
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic tab_rd;
      logic tab_cmp;
      logic declare_end;
      logic edge_rd;
      logic edge_end;
      logic clear_all;
      logic loop_rd;
      logic loop_wr;
      logic loop_done;
      logic pair_row;
      logic pair_cache;
      logic pair_rd;
      logic pair_cmp;
      logic pair_next;
      logic set_totals;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_declare;
      logic scan_more;
      logic i_more;
      logic i_pair_more;
      logic j_more;
   } stat_type;

endpackage

// ----- rtl/dyad_reciprocity_counter_unit.sv -----
// Directed-graph reciprocity counter.
// Input beat: start with req_kind and ids, taken when start is high and busy
// is low. Kinds: declare node (req_node_id), add edge (req_source_id,
// req_target_id), compute totals, clear store.
// Result beat: rsp_valid is high for one cycle with rsp_status, the counts
// and rsp_node_total; busy drops in the following cycle. Counts other than
// node total are zero except on totals. The receiver cannot stall.
// Steps per kind, n = declared nodes:
//   declare: id table scanned one entry at a time, then the new id appended
//   edge:    same scan, then read-modify-write of one row
//   compute: self-loop sweep of the n rows, then walk of rows j > i for each
//            i < n-1, through the single read port of the adjacency row memory
//   clear:   row valid bits and node count dropped at once
// One item at a time. Reset empties the node table and the adjacency store
// by zeroing the node count and row valid bits; no clearing pass is needed.
module dyad_reciprocity_counter_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_kind,
   input  logic [drc_pkg::ID_W-1:0]    req_node_id,
   input  logic [drc_pkg::ID_W-1:0]    req_source_id,
   input  logic [drc_pkg::ID_W-1:0]    req_target_id,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic [drc_pkg::PAIR_W-1:0]  rsp_pair_count,
   output logic [drc_pkg::PAIR_W-1:0]  rsp_reciprocated_count,
   output logic [drc_pkg::CNT_W-1:0]   rsp_self_loop_count,
   output logic [drc_pkg::CNT_W-1:0]   rsp_node_total
);
   import drc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   drc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_kind),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   drc_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .req_kind               (req_kind),
      .req_node_id            (req_node_id),
      .req_source_id          (req_source_id),
      .req_target_id          (req_target_id),
      .stat                   (stat),
      .rsp_status             (rsp_status),
      .rsp_pair_count         (rsp_pair_count),
      .rsp_reciprocated_count (rsp_reciprocated_count),
      .rsp_self_loop_count    (rsp_self_loop_count),
      .rsp_node_total         (rsp_node_total)
   );

   // one result beat per item, then idle
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result beat not followed by idle");

   a_beat_ends_item: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid))
      else $error("item finished without result beat");

   a_counts_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_TOTALS |->
         rsp_pair_count == '0 && rsp_reciprocated_count == '0 &&
         rsp_self_loop_count == '0)
      else $error("counts set outside totals");

   a_node_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_node_total <= CNT_W'(MAX_NODES)
         && rsp_reciprocated_count <= rsp_pair_count)
      else $error("node total or pair counts out of range");

endmodule

// ----- rtl/drc_ctrl.sv -----
module drc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_kind,
   input  drc_pkg::stat_type  stat,
   output drc_pkg::cmd_type   cmd,
   output logic               busy,
   output logic               rsp_valid
);
   import drc_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = (state_ff != S_IDLE);
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (kind_type'(req_kind))
                  KIND_DECLARE, KIND_EDGE: state_in = S_SEARCH;
                  KIND_COMPUTE:            state_in = S_LOOP_RD;
                  default:                 state_in = S_CLEAR;
               endcase
            end
         end
         S_SEARCH: begin
            if (stat.scan_more) begin
               cmd.tab_rd = 1'b1;
               state_in   = S_CMP;
            end else if (stat.is_declare) begin
               cmd.declare_end = 1'b1;
               state_in        = S_RESPOND;
            end else begin
               state_in = S_EDGE_RD;
            end
         end
         S_CMP: begin
            cmd.tab_cmp = 1'b1;
            state_in    = S_SEARCH;
         end
         S_EDGE_RD: begin
            cmd.edge_rd = 1'b1;
            state_in    = S_EDGE_WR;
         end
         S_EDGE_WR: begin
            cmd.edge_end = 1'b1;
            state_in     = S_RESPOND;
         end
         S_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_in      = S_RESPOND;
         end
         // self-loop sweep
         S_LOOP_RD: begin
            if (stat.i_more) begin
               cmd.loop_rd = 1'b1;
               state_in    = S_LOOP_WR;
            end else begin
               cmd.loop_done = 1'b1;
               state_in      = S_PAIR_ROW;
            end
         end
         S_LOOP_WR: begin
            cmd.loop_wr = 1'b1;
            state_in    = S_LOOP_RD;
         end
         // pair walk over upper triangle
         S_PAIR_ROW: begin
            if (stat.i_pair_more) begin
               cmd.pair_row = 1'b1;
               state_in     = S_PAIR_CACHE;
            end else begin
               cmd.set_totals = 1'b1;
               state_in       = S_RESPOND;
            end
         end
         S_PAIR_CACHE: begin
            cmd.pair_cache = 1'b1;
            state_in       = S_PAIR_RD;
         end
         S_PAIR_RD: begin
            if (stat.j_more) begin
               cmd.pair_rd = 1'b1;
               state_in    = S_PAIR_CMP;
            end else begin
               cmd.pair_next = 1'b1;
               state_in      = S_PAIR_ROW;
            end
         end
         S_PAIR_CMP: begin
            cmd.pair_cmp = 1'b1;
            state_in     = S_PAIR_RD;
         end
         S_RESPOND: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ----- rtl/drc_datapath.sv -----
module drc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  drc_pkg::cmd_type               cmd,
   input  logic [1:0]                     req_kind,
   input  logic [drc_pkg::ID_W-1:0]       req_node_id,
   input  logic [drc_pkg::ID_W-1:0]       req_source_id,
   input  logic [drc_pkg::ID_W-1:0]       req_target_id,
   output drc_pkg::stat_type              stat,
   output logic [2:0]                     rsp_status,
   output logic [drc_pkg::PAIR_W-1:0]     rsp_pair_count,
   output logic [drc_pkg::PAIR_W-1:0]     rsp_reciprocated_count,
   output logic [drc_pkg::CNT_W-1:0]      rsp_self_loop_count,
   output logic [drc_pkg::CNT_W-1:0]      rsp_node_total
);
   import drc_pkg::*;

   // node id table and adjacency rows
   logic [ID_W-1:0]      node_mem [MAX_NODES];
   logic [MAX_NODES-1:0] adj_mem  [MAX_NODES];
   logic [MAX_NODES-1:0] row_valid_ff;

   kind_type             kind_ff;
   logic [ID_W-1:0]      id_a_ff, id_b_ff, tab_q_ff;
   logic [CNT_W-1:0]     scan_ff, count_ff, i_ff, j_ff, loops_ff;
   logic                 found_a_ff, found_b_ff;
   logic [IDX_W-1:0]     pos_a_ff, pos_b_ff;
   logic [MAX_NODES-1:0] adj_q_ff, cache_ff, row_q;
   logic                 adj_qv_ff;
   logic [PAIR_W-1:0]    pairs_ff, recip_ff;
   status_type           status_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 rd_en, bit_a, bit_b;

   // unwritten rows read as empty
   assign row_q = adj_qv_ff ? adj_q_ff : '0;

   always_comb begin
      rd_addr = pos_a_ff;
      if (cmd.loop_rd || cmd.pair_row) begin
         rd_addr = i_ff[IDX_W-1:0];
      end else if (cmd.pair_rd) begin
         rd_addr = j_ff[IDX_W-1:0];
      end
   end
   assign rd_en = cmd.edge_rd | cmd.loop_rd | cmd.pair_row | cmd.pair_rd;

   assign bit_a = cache_ff[j_ff[IDX_W-1:0]];
   assign bit_b = row_q[i_ff[IDX_W-1:0]];

   // memories
   always_ff @(posedge clock) begin
      if (cmd.tab_rd) begin
         tab_q_ff <= node_mem[scan_ff[IDX_W-1:0]];
      end
      if (cmd.declare_end && !found_a_ff && count_ff != CNT_W'(MAX_NODES)) begin
         node_mem[count_ff[IDX_W-1:0]] <= id_a_ff;
      end
      if (rd_en) begin
         adj_q_ff  <= adj_mem[rd_addr];
         adj_qv_ff <= row_valid_ff[rd_addr];
      end
      if (cmd.edge_end && found_a_ff && found_b_ff && !row_q[pos_b_ff]) begin
         adj_mem[pos_a_ff] <= row_q | (MAX_NODES'(1) << pos_b_ff);
      end else if (cmd.loop_wr) begin
         adj_mem[i_ff[IDX_W-1:0]] <= row_q & ~(MAX_NODES'(1) << i_ff[IDX_W-1:0]);
      end
   end

   // row valid bits and node count
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         row_valid_ff <= '0;
         count_ff     <= '0;
      end else begin
         if (cmd.edge_end && found_a_ff && found_b_ff && !row_q[pos_b_ff]) begin
            row_valid_ff[pos_a_ff] <= 1'b1;
         end else if (cmd.loop_wr) begin
            row_valid_ff[i_ff[IDX_W-1:0]] <= 1'b1;
         end
         if (cmd.declare_end && !found_a_ff && count_ff != CNT_W'(MAX_NODES)) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   // item working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff    <= kind_type'(req_kind);
         id_a_ff    <= (kind_type'(req_kind) == KIND_DECLARE) ? req_node_id : req_source_id;
         id_b_ff    <= req_target_id;
         scan_ff    <= '0;
         found_a_ff <= 1'b0;
         found_b_ff <= 1'b0;
         i_ff       <= '0;
         j_ff       <= '0;
         loops_ff   <= '0;
         pairs_ff   <= '0;
         recip_ff   <= '0;
      end
      if (cmd.tab_cmp) begin
         if (tab_q_ff == id_a_ff) begin
            found_a_ff <= 1'b1;
            pos_a_ff   <= scan_ff[IDX_W-1:0];
         end
         if (tab_q_ff == id_b_ff) begin
            found_b_ff <= 1'b1;
            pos_b_ff   <= scan_ff[IDX_W-1:0];
         end
         scan_ff <= scan_ff + 1'b1;
      end
      if (cmd.loop_wr) begin
         loops_ff <= loops_ff + CNT_W'(bit_b);
         i_ff     <= i_ff + 1'b1;
      end
      if (cmd.loop_done) begin
         i_ff <= '0;
      end
      if (cmd.pair_row) begin
         j_ff <= i_ff + 1'b1;
      end
      if (cmd.pair_cache) begin
         cache_ff <= row_q;
      end
      if (cmd.pair_cmp) begin
         pairs_ff <= pairs_ff + PAIR_W'(bit_a | bit_b);
         recip_ff <= recip_ff + PAIR_W'(bit_a & bit_b);
         j_ff     <= j_ff + 1'b1;
      end
      if (cmd.pair_next) begin
         i_ff <= i_ff + 1'b1;
      end
   end

   // result code
   always_ff @(posedge clock) begin
      if (cmd.declare_end) begin
         if (found_a_ff) begin
            status_ff <= ST_DUPLICATE;
         end else if (count_ff == CNT_W'(MAX_NODES)) begin
            status_ff <= ST_FULL;
         end else begin
            status_ff <= ST_ACCEPTED;
         end
      end else if (cmd.edge_end) begin
         if (!(found_a_ff && found_b_ff)) begin
            status_ff <= ST_UNKNOWN;
         end else if (row_q[pos_b_ff]) begin
            status_ff <= ST_DUPLICATE;
         end else begin
            status_ff <= ST_ACCEPTED;
         end
      end else if (cmd.clear_all) begin
         status_ff <= ST_CLEARED;
      end else if (cmd.set_totals) begin
         status_ff <= ST_TOTALS;
      end
   end

   assign stat.is_declare  = (kind_ff == KIND_DECLARE);
   assign stat.scan_more   = (scan_ff < count_ff);
   assign stat.i_more      = (i_ff < count_ff);
   assign stat.i_pair_more = ((i_ff + 1'b1) < count_ff);
   assign stat.j_more      = (j_ff < count_ff);

   assign rsp_status             = status_ff;
   assign rsp_pair_count         = pairs_ff;
   assign rsp_reciprocated_count = recip_ff;
   assign rsp_self_loop_count    = loops_ff;
   assign rsp_node_total         = count_ff;

endmodule
